[src/slhsb_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo shelving equalizer package
// Shared types and constants for the two-band shelving biquad block.
// ----------------------------------------------------------------------------
package slhsb_pkg;

    // Coefficient field, delay word and configuration register sizes.
    localparam int COEF_W     = 20;
    localparam int DELAY_W    = 32;
    localparam int FF_W       = 60;
    localparam int FB_W       = 40;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FF  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FB  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FF = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FB = 4'd3;

    // Reset values: unity pass-through (b0 = 1.0 in Q3.16), no feedback.
    localparam logic [FF_W-1:0] FF_RESET = 60'd65536;
    localparam logic [FB_W-1:0] FB_RESET = 40'd0;

    // One shelf's five coefficients.
    typedef struct packed {
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b0;
    } t_shelf;

    // Lane sequencer states.
    typedef enum logic [1:0] {
        LS_IDLE,
        LS_MUL,
        LS_ACC,
        LS_HOLD
    } t_lane_state;

    // Multiply-accumulate terms of one biquad, in issue order.
    typedef enum logic [2:0] {
        TERM_B0,
        TERM_B1,
        TERM_A1,
        TERM_B2,
        TERM_A2
    } t_term;

    // Lane status seen by the merge stage and the top level.
    typedef struct packed {
        logic idle;
        logic hold;
    } t_lane_status;

endpackage

[src/slhsb_lane.sv]
// ----------------------------------------------------------------------------
// Shelving equalizer lane
// One channel: low shelf then high shelf, transposed direct form II, computed
// by a single shared multiplier over ten multiply/accumulate steps.
// ----------------------------------------------------------------------------
module slhsb_lane #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  slhsb_pkg::t_shelf             i_low,
    input  slhsb_pkg::t_shelf             i_high,
    input  logic                          i_take,
    output slhsb_pkg::t_lane_status       o_status,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    import slhsb_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int F      = COEF_FRAC_BITS;
    localparam int PROD_W = COEF_W + SB;
    localparam int ACC_W  = ((SB + 19 > DELAY_W - 1 + F) ? SB + 19 : DELAY_W - 1 + F) + 2;
    localparam int RND_W  = ACC_W - F;

    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [RND_W-1:0] Y_MAX =
        {{(RND_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [RND_W-1:0] Y_MIN =
        {{(RND_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [RND_W-1:0] D_MAX =
        {{(RND_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    localparam logic signed [RND_W-1:0] D_MIN =
        {{(RND_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};

    t_lane_state r_state, n_state;
    t_term       r_term;
    logic        r_stage;
    logic signed [SB-1:0]      r_x;
    logic signed [SB-1:0]      r_y;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DELAY_W-1:0] r_s1 [2];
    logic signed [DELAY_W-1:0] r_s2 [2];

    logic mul_en, acc_en;
    t_shelf shelf;
    logic signed [COEF_W-1:0]  mul_coef;
    logic signed [SB-1:0]      mul_op;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W-1:0]   prod_ext, s1_ext, s2_ext, acc_sum, acc_rnd;
    logic signed [RND_W-1:0]   q;
    logic signed [SB-1:0]      y_sat;
    logic signed [DELAY_W-1:0] d_sat;
    logic last_term;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            LS_IDLE: if (i_start) n_state = LS_MUL;
            LS_MUL:  n_state = LS_ACC;
            LS_ACC: begin
                if (last_term && r_stage) n_state = LS_HOLD;
                else                      n_state = LS_MUL;
            end
            LS_HOLD: if (i_take) n_state = LS_IDLE;
            default: n_state = LS_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        mul_en        = 1'b0;
        acc_en        = 1'b0;
        o_status.idle = 1'b0;
        o_status.hold = 1'b0;
        case (r_state)
            LS_IDLE: o_status.idle = 1'b1;
            LS_MUL:  mul_en = 1'b1;
            LS_ACC:  acc_en = 1'b1;
            LS_HOLD: o_status.hold = 1'b1;
            default: o_status.idle = 1'b0;
        endcase
    end

    assign last_term = (r_term == TERM_A2);

    // Coefficient and operand selection for the current term.
    always_comb begin
        shelf = r_stage ? i_high : i_low;
        case (r_term)
            TERM_B0: begin mul_coef = shelf.b0; mul_op = r_x; end
            TERM_B1: begin mul_coef = shelf.b1; mul_op = r_x; end
            TERM_A1: begin mul_coef = shelf.a1; mul_op = r_y; end
            TERM_B2: begin mul_coef = shelf.b2; mul_op = r_x; end
            TERM_A2: begin mul_coef = shelf.a2; mul_op = r_y; end
            default: begin mul_coef = shelf.b0; mul_op = r_x; end
        endcase
        n_prod = mul_coef * mul_op;
    end

    // Accumulate, round half up to the sample grid, then saturate.
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        s1_ext   = {{(ACC_W-DELAY_W-F){r_s1[r_stage][DELAY_W-1]}}, r_s1[r_stage], {F{1'b0}}};
        s2_ext   = {{(ACC_W-DELAY_W-F){r_s2[r_stage][DELAY_W-1]}}, r_s2[r_stage], {F{1'b0}}};
        case (r_term)
            TERM_B0: acc_sum = prod_ext + s1_ext;
            TERM_B1: acc_sum = prod_ext + s2_ext;
            TERM_A1: acc_sum = r_acc - prod_ext;
            TERM_B2: acc_sum = prod_ext;
            TERM_A2: acc_sum = r_acc - prod_ext;
            default: acc_sum = prod_ext;
        endcase
        acc_rnd = acc_sum + ACC_HALF;
        q       = acc_rnd[ACC_W-1:F];
        if (q > Y_MAX)      y_sat = Y_MAX[SB-1:0];
        else if (q < Y_MIN) y_sat = Y_MIN[SB-1:0];
        else                y_sat = q[SB-1:0];
        if (q > D_MAX)      d_sat = D_MAX[DELAY_W-1:0];
        else if (q < D_MIN) d_sat = D_MIN[DELAY_W-1:0];
        else                d_sat = q[DELAY_W-1:0];
    end

    // Control registers and delay words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_term  <= TERM_B0;
            r_stage <= 1'b0;
            r_s1[0] <= '0;
            r_s1[1] <= '0;
            r_s2[0] <= '0;
            r_s2[1] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == LS_IDLE && i_start) begin
                r_term  <= TERM_B0;
                r_stage <= 1'b0;
            end
            if (acc_en) begin
                case (r_term)
                    TERM_B0: r_term <= TERM_B1;
                    TERM_B1: r_term <= TERM_A1;
                    TERM_A1: begin
                        r_term         <= TERM_B2;
                        r_s1[r_stage]  <= d_sat;
                    end
                    TERM_B2: r_term <= TERM_A2;
                    TERM_A2: begin
                        r_term         <= TERM_B0;
                        r_stage        <= ~r_stage;
                        r_s2[r_stage]  <= d_sat;
                    end
                    default: r_term <= TERM_B0;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == LS_IDLE && i_start) r_x <= i_x;
        if (mul_en) r_prod <= n_prod;
        if (acc_en) begin
            r_acc <= acc_sum;
            if (r_term == TERM_B0) r_y <= y_sat;
            // The low shelf output feeds the high shelf.
            if (last_term && !r_stage) r_x <= r_y;
        end
    end

    assign o_y = r_y;

endmodule

[src/slhsb_merge.sv]
// ----------------------------------------------------------------------------
// Shelving equalizer merge stage
// Joins the two lane results into one output beat and holds it until taken.
// ----------------------------------------------------------------------------
module slhsb_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slhsb_pkg::t_lane_status       i_left_status,
    input  slhsb_pkg::t_lane_status       i_right_status,
    input  logic signed [SAMPLE_BITS-1:0] i_left_y,
    input  logic signed [SAMPLE_BITS-1:0] i_right_y,
    output logic                          o_take,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // left_out, right_out
    output logic [2*SAMPLE_BITS-1:0]      o_pair
);
    import slhsb_pkg::*;

    logic                     r_valid;
    logic [2*SAMPLE_BITS-1:0] r_pair;

    // Load when both lanes hold a result and the output slot is free.
    assign o_take = i_left_status.hold && i_right_status.hold
                    && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_pair <= {i_right_y, i_left_y};
    end

    assign m_axis_tvalid = r_valid;
    assign o_pair        = r_pair;

endmodule

[src/stereo_low_high_shelf_biquad.sv]
// ----------------------------------------------------------------------------
// Stereo low/high shelving biquad equalizer
// Two channel lanes, each a low shelf followed by a high shelf, merged into
// one output beat per input beat.
// ----------------------------------------------------------------------------
// Each lane works through a stereo pair in ten multiply/accumulate steps on
// its single multiplier, and takes no new pair until its result has moved to
// the output register. The next pair is accepted while a finished result
// waits on the output.
// Reset (synchronous, active low) clears all delay words and loads unity
// low and high shelves.
module stereo_low_high_shelf_biquad #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slhsb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slhsb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // left_in, right_in (from bit 0 up), zero padded to whole bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // left_out, right_out (from bit 0 up), zero padded to whole bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata
);
    import slhsb_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int DATA_W = ((2*SB+7)/8)*8;

    logic [FF_W-1:0] r_low_ff, r_high_ff;
    logic [FB_W-1:0] r_low_fb, r_high_fb;
    t_shelf          low_shelf, high_shelf;
    t_lane_status    left_status, right_status;
    logic signed [SB-1:0] left_y, right_y;
    logic            take, start;
    logic [2*SB-1:0] pair;

    // Coefficient registers; unlisted indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_ff  <= FF_RESET;
            r_low_fb  <= FB_RESET;
            r_high_ff <= FF_RESET;
            r_high_fb <= FB_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOW_FF:  r_low_ff  <= i_cfg_data[FF_W-1:0];
                REG_LOW_FB:  r_low_fb  <= i_cfg_data[FB_W-1:0];
                REG_HIGH_FF: r_high_ff <= i_cfg_data[FF_W-1:0];
                REG_HIGH_FB: r_high_fb <= i_cfg_data[FB_W-1:0];
                default:     r_low_ff  <= r_low_ff;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign low_shelf   = {r_low_fb, r_low_ff};
    assign high_shelf  = {r_high_fb, r_high_ff};

    // Both lanes run in lockstep, so both are idle together.
    assign s_axis_tready = left_status.idle && right_status.idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    slhsb_lane #(
        .SAMPLE_BITS   (SB),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x     (s_axis_tdata[SB-1:0]),
        .i_low   (low_shelf),
        .i_high  (high_shelf),
        .i_take  (take),
        .o_status(left_status),
        .o_y     (left_y)
    );

    slhsb_lane #(
        .SAMPLE_BITS   (SB),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x     (s_axis_tdata[2*SB-1:SB]),
        .i_low   (low_shelf),
        .i_high  (high_shelf),
        .i_take  (take),
        .o_status(right_status),
        .o_y     (right_y)
    );

    slhsb_merge #(
        .SAMPLE_BITS(SB)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_left_status (left_status),
        .i_right_status(right_status),
        .i_left_y      (left_y),
        .i_right_y     (right_y),
        .o_take        (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_pair        (pair)
    );

    assign m_axis_tdata = DATA_W'(pair);

endmodule
